// ----- rtl/core/ecnfa_pkg.sv -----
// Shared types, constants and command/status structs for the ECN fraction alpha estimator.
`default_nettype none

package ecnfa_pkg;

    localparam int SEQ_W       = 32;
    localparam int ALPHA_W     = 11;
    localparam int MSS_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int LOSS_TH_W   = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SHIFT_MAX   = 10;
    localparam int QUO_W       = SHIFT_MAX + 1;
    localparam int NUM_W       = SEQ_W + SHIFT_MAX;
    localparam int PROD_W      = SEQ_W + ALPHA_W;
    localparam int DIV_CNT_W   = 4;

    localparam logic [ALPHA_W-1:0]   ALPHA_MAX      = ALPHA_W'(1024);
    localparam logic [SHIFT_W-1:0]   GAIN_SHIFT_RST = SHIFT_W'(4);
    localparam logic [SHIFT_W-1:0]   GAIN_SHIFT_LIM = SHIFT_W'(SHIFT_MAX);
    localparam logic [SEQ_W-1:0]     THRESH_MIN     = SEQ_W'(2);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT   = DIV_CNT_W'(QUO_W - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ON_LOSS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd3;

    typedef struct packed {
        logic [SEQ_W-1:0] acked_seq;
        logic [SEQ_W-1:0] send_next_seq;
        logic [MSS_W-1:0] segment_size;
        logic             echo_marked;
        logic             window_update_only;
        logic [SEQ_W-1:0] congestion_window;
        logic             loss_entered;
    } ecnfa_in_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]   alpha_out;
        logic                 window_closed;
        logic [SEQ_W-1:0]     ecn_threshold;
        logic [LOSS_TH_W-1:0] loss_threshold;
    } ecnfa_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECAY,
        ST_DIV,
        ST_ACCUM,
        ST_LOSS,
        ST_MULT,
        ST_FINISH
    } ecnfa_state_t;

    typedef struct packed {
        logic load;
        logic count;
        logic decay;
        logic div_step;
        logic accum;
        logic loss;
        logic mult;
        logic finish;
    } ecnfa_cmd_t;

    typedef struct packed {
        logic closed;
        logic go_div;
        logic div_last;
        logic out_free;
    } ecnfa_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ecn_fraction_alpha_estimator_core.sv -----
// Top level of the ECN marked-fraction (alpha) estimator: controller plus datapath.
// A transaction passes through count, loss clamp, multiply and finish when the ACK does not
// close an observation window; decay and accumulation are added when it closes one without a
// division, and decay, the serial divider and accumulation when the marked share is divided.
// A full output register stalls the finish state. A new transaction is taken only once the last
// has returned to idle; the restoring divider, one quotient bit per cycle, is the longest path.
// Reset (aresetn low, synchronous) loads the register defaults, alpha 1024 and empty counters.
`default_nettype none

module ecn_fraction_alpha_estimator_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire ecnfa_pkg::ecnfa_in_t                 s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ecnfa_pkg::ecnfa_out_t                     m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ecnfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ecnfa_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // The controller walks each transaction through counting, window close (decay, division,
    // accumulation), the loss clamp, the threshold multiply and the final threshold compare.
    // It accepts a new transaction only from its idle state, so one ACK is in flight at a time.
    ecnfa_pkg::ecnfa_cmd_t    cmd;
    ecnfa_pkg::ecnfa_status_t status;

    ecnfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the alpha estimate, the sequence tracking and the
    // byte counters. Results sit in an output register, so the next transaction can be taken
    // while a finished result still waits for the consumer.
    ecnfa_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ecnfa_ctrl.sv -----
// Controller state machine that sequences one ACK transaction through the datapath.
`default_nettype none

module ecnfa_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire ecnfa_pkg::ecnfa_status_t status,
    output ecnfa_pkg::ecnfa_cmd_t         cmd
);

    ecnfa_pkg::ecnfa_state_t state_reg;
    ecnfa_pkg::ecnfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ecnfa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ecnfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ecnfa_pkg::ST_COUNT;
                end
            end
            ecnfa_pkg::ST_COUNT: begin
                state_next = status.closed ? ecnfa_pkg::ST_DECAY : ecnfa_pkg::ST_LOSS;
            end
            ecnfa_pkg::ST_DECAY: begin
                state_next = status.go_div ? ecnfa_pkg::ST_DIV : ecnfa_pkg::ST_ACCUM;
            end
            ecnfa_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = ecnfa_pkg::ST_ACCUM;
                end
            end
            ecnfa_pkg::ST_ACCUM:  state_next = ecnfa_pkg::ST_LOSS;
            ecnfa_pkg::ST_LOSS:   state_next = ecnfa_pkg::ST_MULT;
            ecnfa_pkg::ST_MULT:   state_next = ecnfa_pkg::ST_FINISH;
            ecnfa_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ecnfa_pkg::ST_IDLE;
                end
            end
            default: state_next = ecnfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ecnfa_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ecnfa_pkg::ST_COUNT:  cmd.count    = 1'b1;
            ecnfa_pkg::ST_DECAY:  cmd.decay    = 1'b1;
            ecnfa_pkg::ST_DIV:    cmd.div_step = 1'b1;
            ecnfa_pkg::ST_ACCUM:  cmd.accum    = 1'b1;
            ecnfa_pkg::ST_LOSS:   cmd.loss     = 1'b1;
            ecnfa_pkg::ST_MULT:   cmd.mult     = 1'b1;
            ecnfa_pkg::ST_FINISH: cmd.finish   = status.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ecnfa_datapath.sv -----
// Datapath: estimator state, byte counters, serial divider, threshold multiplier, output register.
`default_nettype none

module ecnfa_datapath (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire ecnfa_pkg::ecnfa_cmd_t                        cmd,
    output ecnfa_pkg::ecnfa_status_t                          status,
    input  wire logic                                         cfg_wr_en,
    input  wire logic [ecnfa_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [ecnfa_pkg::CFG_DATA_W-1:0]             cfg_wr_data,
    input  wire ecnfa_pkg::ecnfa_in_t                         s_data,
    output logic                                              m_valid,
    input  wire logic                                         m_ready,
    output ecnfa_pkg::ecnfa_out_t                             m_data
);

    localparam int SEQ_W   = ecnfa_pkg::SEQ_W;
    localparam int ALPHA_W = ecnfa_pkg::ALPHA_W;
    localparam int NUM_W   = ecnfa_pkg::NUM_W;
    localparam int PROD_W  = ecnfa_pkg::PROD_W;
    localparam int QUO_W   = ecnfa_pkg::QUO_W;

    // Configuration and estimator state.
    logic [ecnfa_pkg::SHIFT_W-1:0]   gain_shift_reg, gain_shift_next;
    logic                            clamp_reg, clamp_next;
    logic [ALPHA_W-1:0]              alpha_reg, alpha_next;
    logic [SEQ_W-1:0]                last_acked_reg, last_acked_next;
    logic [SEQ_W-1:0]                window_end_reg, window_end_next;
    logic [SEQ_W-1:0]                total_reg, total_next;
    logic [SEQ_W-1:0]                marked_reg, marked_next;

    // Per-transaction working registers.
    ecnfa_pkg::ecnfa_in_t            in_reg, in_next;
    logic                            closed_reg, closed_next;
    logic [ALPHA_W-1:0]              awork_reg, awork_next;
    logic                            share_reg, share_next;
    logic                            sat_reg, sat_next;
    logic [NUM_W-1:0]                rem_reg, rem_next;
    logic [NUM_W-1:0]                dsh_reg, dsh_next;
    logic [QUO_W-1:0]                quo_reg, quo_next;
    logic [ecnfa_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    ecnfa_pkg::ecnfa_out_t           out_reg, out_next;
    logic                            m_valid_reg, m_valid_next;

    // Combinational helpers.
    logic [SEQ_W-1:0]                acked_raw;
    logic [SEQ_W-1:0]                acked;
    logic [SEQ_W-1:0]                win_span;
    logic [ecnfa_pkg::SHIFT_W-1:0]   g_eff;
    logic [ALPHA_W-1:0]              dec_raw;
    logic [ALPHA_W-1:0]              dec;
    logic [NUM_W-1:0]                num;
    logic [SEQ_W-1:0]                den;
    logic                            sat_now;
    logic                            rem_ge;
    logic [ALPHA_W:0]                alpha_sum;
    logic [SEQ_W-1:0]                red;
    logic [SEQ_W-1:0]                ecn_diff;
    logic [ecnfa_pkg::LOSS_TH_W-1:0] half_cwnd;
    logic [ALPHA_W-1:0]              cfg_alpha;

    always_comb begin
        acked_raw = in_reg.acked_seq - last_acked_reg;
        if (acked_raw == '0 && !in_reg.window_update_only) begin
            acked = SEQ_W'(in_reg.segment_size);
        end else begin
            acked = acked_raw;
        end
        win_span = in_reg.acked_seq - window_end_reg;

        g_eff   = (gain_shift_reg > ecnfa_pkg::GAIN_SHIFT_LIM) ? ecnfa_pkg::GAIN_SHIFT_LIM
                                                               : gain_shift_reg;
        dec_raw = alpha_reg >> g_eff;
        dec     = (dec_raw == '0) ? alpha_reg : dec_raw;
        num     = NUM_W'(marked_reg) << (ecnfa_pkg::GAIN_SHIFT_LIM - g_eff);
        den     = (total_reg == '0) ? SEQ_W'(1) : total_reg;
        // A share of 2048 or more saturates alpha whatever the decayed value is.
        sat_now = {1'b0, num} >= ((NUM_W + 1)'(den) << QUO_W);
        rem_ge  = rem_reg >= dsh_reg;

        alpha_sum = {1'b0, awork_reg} + {1'b0, quo_reg};

        red       = prod_reg[PROD_W-1:ALPHA_W];
        ecn_diff  = in_reg.congestion_window - red;
        half_cwnd = in_reg.congestion_window[SEQ_W-1:1];

        cfg_alpha = (cfg_wr_data[ALPHA_W-1:0] > ecnfa_pkg::ALPHA_MAX) ? ecnfa_pkg::ALPHA_MAX
                                                                       : cfg_wr_data[ALPHA_W-1:0];
    end

    always_comb begin
        status.closed   = ~win_span[SEQ_W-1];
        status.go_div   = (marked_reg != '0) && !sat_now;
        status.div_last = (cnt_reg == '0);
        status.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        gain_shift_next = gain_shift_reg;
        clamp_next      = clamp_reg;
        alpha_next      = alpha_reg;
        last_acked_next = last_acked_reg;
        window_end_next = window_end_reg;
        total_next      = total_reg;
        marked_next     = marked_reg;
        in_next         = in_reg;
        closed_next     = closed_reg;
        awork_next      = awork_reg;
        share_next      = share_reg;
        sat_next        = sat_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                ecnfa_pkg::CFG_GAIN_SHIFT:
                    gain_shift_next = cfg_wr_data[ecnfa_pkg::SHIFT_W-1:0];
                ecnfa_pkg::CFG_INITIAL_ALPHA:
                    alpha_next = cfg_alpha;
                ecnfa_pkg::CFG_CLAMP_ON_LOSS:
                    clamp_next = cfg_wr_data[0];
                ecnfa_pkg::CFG_START_SEQUENCE: begin
                    last_acked_next = cfg_wr_data[SEQ_W-1:0];
                    window_end_next = cfg_wr_data[SEQ_W-1:0];
                end
                default: ;
            endcase
        end

        if (cmd.load) begin
            in_next = s_data;
        end

        if (cmd.count) begin
            closed_next = status.closed;
            if (acked != '0) begin
                total_next      = total_reg + acked;
                last_acked_next = in_reg.acked_seq;
                if (in_reg.echo_marked) begin
                    marked_next = marked_reg + acked;
                end
            end
        end

        if (cmd.decay) begin
            awork_next      = alpha_reg - dec;
            share_next      = (marked_reg != '0);
            sat_next        = sat_now;
            rem_next        = num;
            dsh_next        = NUM_W'(den) << ecnfa_pkg::SHIFT_MAX;
            quo_next        = '0;
            cnt_next        = ecnfa_pkg::DIV_LAST_BIT;
            window_end_next = in_reg.send_next_seq;
            total_next      = '0;
            marked_next     = '0;
        end

        // Restoring division, one quotient bit per cycle, most significant first.
        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QUO_W-2:0], rem_ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.accum) begin
            if (!share_reg) begin
                alpha_next = awork_reg;
            end else if (sat_reg || alpha_sum > {1'b0, ecnfa_pkg::ALPHA_MAX}) begin
                alpha_next = ecnfa_pkg::ALPHA_MAX;
            end else begin
                alpha_next = alpha_sum[ALPHA_W-1:0];
            end
        end

        if (cmd.loss && clamp_reg && in_reg.loss_entered) begin
            alpha_next = ecnfa_pkg::ALPHA_MAX;
        end

        if (cmd.mult) begin
            prod_next = PROD_W'(in_reg.congestion_window) * PROD_W'(alpha_reg);
        end

        if (cmd.finish) begin
            out_next.alpha_out     = alpha_reg;
            out_next.window_closed = closed_reg;
            if (red >= in_reg.congestion_window || ecn_diff < ecnfa_pkg::THRESH_MIN) begin
                out_next.ecn_threshold = ecnfa_pkg::THRESH_MIN;
            end else begin
                out_next.ecn_threshold = ecn_diff;
            end
            if (half_cwnd < ecnfa_pkg::LOSS_TH_W'(ecnfa_pkg::THRESH_MIN)) begin
                out_next.loss_threshold = ecnfa_pkg::LOSS_TH_W'(ecnfa_pkg::THRESH_MIN);
            end else begin
                out_next.loss_threshold = half_cwnd;
            end
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_shift_reg <= ecnfa_pkg::GAIN_SHIFT_RST;
            clamp_reg      <= 1'b0;
            alpha_reg      <= ecnfa_pkg::ALPHA_MAX;
            last_acked_reg <= '0;
            window_end_reg <= '0;
            total_reg      <= '0;
            marked_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            gain_shift_reg <= gain_shift_next;
            clamp_reg      <= clamp_next;
            alpha_reg      <= alpha_next;
            last_acked_reg <= last_acked_next;
            window_end_reg <= window_end_next;
            total_reg      <= total_next;
            marked_reg     <= marked_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        closed_reg <= closed_next;
        awork_reg  <= awork_next;
        share_reg  <= share_next;
        sat_reg    <= sat_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Alpha stays within its full-scale value.
    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        alpha_reg <= ecnfa_pkg::ALPHA_MAX)
        else $error("alpha above full scale");

    // The controller only loads the output register when it is free.
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    // Restoring division invariant: the partial remainder is below twice the divisor step.
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");

    // Counters are empty after a window closes.
    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decay |=> (total_reg == '0 && marked_reg == '0))
        else $error("counters not cleared at window end");

endmodule

`default_nettype wire
